[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the servo release sequencer.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/srs_pkg.sv]
// Package for the servo release sequencer: widths, register indexes,
// reset values and phase codes. Depends on nothing.
package srs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int PULSE_W    = 16;
    localparam int FRAMES_W   = 8;
    localparam int HOLD_W     = 23;
    localparam int LAMP_W     = 20;
    localparam int SERVO_TMR_W = HOLD_W;
    localparam int LAMP_TMR_W  = LAMP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PULSE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_PULSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMP_ON     = 3'd6;

    localparam logic [PULSE_W-1:0]  RST_OPEN_PULSE  = 16'd1450;
    localparam logic [PULSE_W-1:0]  RST_CLOSE_PULSE = 16'd500;
    localparam logic [PULSE_W-1:0]  RST_FRAME_GAP   = 16'd18550;
    localparam logic [FRAMES_W-1:0] RST_FRAMES      = 8'd250;
    localparam logic [HOLD_W-1:0]   RST_HOLD_TIME   = 23'd5000000;
    localparam logic [PULSE_W-1:0]  RST_DEBOUNCE    = 16'd5000;
    localparam logic [LAMP_W-1:0]   RST_LAMP_ON     = 20'd1000000;

    typedef logic [2:0] servo_phase_t;
    localparam servo_phase_t SP_IDLE       = 3'd0;
    localparam servo_phase_t SP_DEBOUNCE   = 3'd1;
    localparam servo_phase_t SP_OPEN_HIGH  = 3'd2;
    localparam servo_phase_t SP_OPEN_LOW   = 3'd3;
    localparam servo_phase_t SP_HOLD       = 3'd4;
    localparam servo_phase_t SP_CLOSE_HIGH = 3'd5;
    localparam servo_phase_t SP_CLOSE_LOW  = 3'd6;

    typedef logic [1:0] lamp_phase_t;
    localparam lamp_phase_t LP_IDLE     = 2'd0;
    localparam lamp_phase_t LP_DEBOUNCE = 2'd1;
    localparam lamp_phase_t LP_LIT      = 2'd2;

endpackage

[rtl/servo_release_sequencer_top.sv]
// Servo release sequencer: trigger debounce, open/hold/close servo frames,
// sensor-driven LED timer. Depends on srs_pkg and assert_macros.svh.

// Each input item is one microsecond tick of the trigger and sensor pins and
// produces exactly one result item with the servo level, the LED level and a
// busy flag, all showing the state after that tick. The block takes one item
// per clock: the whole state update is one pass of logic from the state
// registers to the result register, and the result appears in the cycle after
// its item is accepted. The output register lets a new item in while the
// previous result is being taken, so a stall stops input only when a result
// is waiting and the output side is not ready. Configuration writes apply at
// the clock edge where cfg_write is high; write them only while idle.
`include "assert_macros.svh"

module servo_release_sequencer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           trigger_level,
    input  logic                           sensor_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           servo_drive,
    output logic                           lamp_drive,
    output logic                           servo_active
);

    logic [srs_pkg::PULSE_W-1:0]  open_pulse_reg;
    logic [srs_pkg::PULSE_W-1:0]  close_pulse_reg;
    logic [srs_pkg::PULSE_W-1:0]  frame_gap_reg;
    logic [srs_pkg::FRAMES_W-1:0] frames_reg;
    logic [srs_pkg::HOLD_W-1:0]   hold_time_reg;
    logic [srs_pkg::PULSE_W-1:0]  debounce_reg;
    logic [srs_pkg::LAMP_W-1:0]   lamp_on_reg;

    srs_pkg::servo_phase_t          servo_phase_reg, servo_phase_next;
    logic [srs_pkg::SERVO_TMR_W-1:0] servo_timer_reg, servo_timer_next;
    logic [srs_pkg::FRAMES_W-1:0]   frame_count_reg, frame_count_next;
    logic                           pending_reg, pending_next;
    logic                           prev_trigger_reg;
    srs_pkg::lamp_phase_t           lamp_phase_reg, lamp_phase_next;
    logic [srs_pkg::LAMP_TMR_W-1:0] lamp_timer_reg, lamp_timer_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           servo_drive_reg;
    logic                           lamp_drive_reg;
    logic                           servo_active_reg;

    logic                           in_fire;
    logic [srs_pkg::SERVO_TMR_W:0]  servo_inc;
    logic [srs_pkg::SERVO_TMR_W:0]  servo_limit;
    logic                           servo_done;
    logic [srs_pkg::FRAMES_W-1:0]   frame_inc;
    logic                           frames_sent;
    logic [srs_pkg::LAMP_TMR_W:0]   lamp_inc;
    logic [srs_pkg::LAMP_TMR_W:0]   lamp_limit;
    logic                           lamp_done;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign servo_drive  = servo_drive_reg;
    assign lamp_drive   = lamp_drive_reg;
    assign servo_active = servo_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_pulse_reg  <= srs_pkg::RST_OPEN_PULSE;
            close_pulse_reg <= srs_pkg::RST_CLOSE_PULSE;
            frame_gap_reg   <= srs_pkg::RST_FRAME_GAP;
            frames_reg      <= srs_pkg::RST_FRAMES;
            hold_time_reg   <= srs_pkg::RST_HOLD_TIME;
            debounce_reg    <= srs_pkg::RST_DEBOUNCE;
            lamp_on_reg     <= srs_pkg::RST_LAMP_ON;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                srs_pkg::CFG_OPEN_PULSE:  open_pulse_reg  <= cfg_data[srs_pkg::PULSE_W-1:0];
                srs_pkg::CFG_CLOSE_PULSE: close_pulse_reg <= cfg_data[srs_pkg::PULSE_W-1:0];
                srs_pkg::CFG_FRAME_GAP:   frame_gap_reg   <= cfg_data[srs_pkg::PULSE_W-1:0];
                srs_pkg::CFG_FRAMES:      frames_reg      <= cfg_data[srs_pkg::FRAMES_W-1:0];
                srs_pkg::CFG_HOLD_TIME:   hold_time_reg   <= cfg_data[srs_pkg::HOLD_W-1:0];
                srs_pkg::CFG_DEBOUNCE:    debounce_reg    <= cfg_data[srs_pkg::PULSE_W-1:0];
                srs_pkg::CFG_LAMP_ON:     lamp_on_reg     <= cfg_data[srs_pkg::LAMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The servo timer is shared by all timed phases; the limit follows the phase.
    always_comb
    begin
        case (servo_phase_reg) inside
            srs_pkg::SP_DEBOUNCE:   servo_limit = {8'd0, debounce_reg};
            srs_pkg::SP_OPEN_HIGH:  servo_limit = {8'd0, open_pulse_reg};
            srs_pkg::SP_CLOSE_HIGH: servo_limit = {8'd0, close_pulse_reg};
            srs_pkg::SP_OPEN_LOW,
            srs_pkg::SP_CLOSE_LOW:  servo_limit = {8'd0, frame_gap_reg};
            srs_pkg::SP_HOLD:       servo_limit = {1'b0, hold_time_reg};
            default:                servo_limit = '0;
        endcase
        case (lamp_phase_reg)
            srs_pkg::LP_DEBOUNCE: lamp_limit = {5'd0, debounce_reg};
            srs_pkg::LP_LIT:      lamp_limit = {1'b0, lamp_on_reg};
            default:              lamp_limit = '0;
        endcase
    end

    assign servo_inc   = {1'b0, servo_timer_reg} + 24'd1;
    assign servo_done  = servo_inc >= servo_limit;
    assign frame_inc   = frame_count_reg + 8'd1;
    assign frames_sent = frame_inc == frames_reg;
    assign lamp_inc    = {1'b0, lamp_timer_reg} + 21'd1;
    assign lamp_done   = lamp_inc >= lamp_limit;

    always_comb
    begin
        servo_phase_next = servo_phase_reg;
        servo_timer_next = servo_done ? '0 : servo_inc[srs_pkg::SERVO_TMR_W-1:0];
        frame_count_next = frame_count_reg;
        pending_next     = pending_reg || (prev_trigger_reg && !trigger_level);

        unique case (servo_phase_reg)
            srs_pkg::SP_DEBOUNCE:
            begin
                if (servo_done)
                begin
                    if (!trigger_level)
                    begin
                        pending_next     = 1'b0;
                        frame_count_next = '0;
                        servo_phase_next = srs_pkg::SP_OPEN_HIGH;
                    end
                    else
                    begin
                        servo_phase_next = srs_pkg::SP_IDLE;
                    end
                end
            end
            srs_pkg::SP_OPEN_HIGH:
            begin
                if (servo_done)
                begin
                    servo_phase_next = srs_pkg::SP_OPEN_LOW;
                end
            end
            srs_pkg::SP_OPEN_LOW:
            begin
                if (servo_done)
                begin
                    frame_count_next = frame_inc;
                    servo_phase_next = frames_sent ? srs_pkg::SP_HOLD : srs_pkg::SP_OPEN_HIGH;
                end
            end
            srs_pkg::SP_HOLD:
            begin
                if (servo_done)
                begin
                    frame_count_next = '0;
                    servo_phase_next = srs_pkg::SP_CLOSE_HIGH;
                end
            end
            srs_pkg::SP_CLOSE_HIGH:
            begin
                if (servo_done)
                begin
                    servo_phase_next = srs_pkg::SP_CLOSE_LOW;
                end
            end
            srs_pkg::SP_CLOSE_LOW:
            begin
                if (servo_done)
                begin
                    if (frames_sent)
                    begin
                        frame_count_next = '0;
                        servo_phase_next = srs_pkg::SP_IDLE;
                    end
                    else
                    begin
                        frame_count_next = frame_inc;
                        servo_phase_next = srs_pkg::SP_CLOSE_HIGH;
                    end
                end
            end
            default:
            begin
                servo_timer_next = servo_timer_reg;
                servo_phase_next = srs_pkg::SP_IDLE;
                if (pending_next && !trigger_level)
                begin
                    servo_timer_next = '0;
                    servo_phase_next = srs_pkg::SP_DEBOUNCE;
                end
            end
        endcase
    end

    // The lamp only advances on ticks that leave the servo sequencer idle.
    always_comb
    begin
        lamp_phase_next = lamp_phase_reg;
        lamp_timer_next = lamp_timer_reg;
        if (servo_phase_next == srs_pkg::SP_IDLE)
        begin
            lamp_timer_next = lamp_done ? '0 : lamp_inc[srs_pkg::LAMP_TMR_W-1:0];
            unique case (lamp_phase_reg)
                srs_pkg::LP_DEBOUNCE:
                begin
                    if (lamp_done)
                    begin
                        lamp_phase_next = sensor_level ? srs_pkg::LP_IDLE : srs_pkg::LP_LIT;
                    end
                end
                srs_pkg::LP_LIT:
                begin
                    if (lamp_done)
                    begin
                        lamp_phase_next = srs_pkg::LP_IDLE;
                    end
                end
                default:
                begin
                    lamp_timer_next = lamp_timer_reg;
                    lamp_phase_next = srs_pkg::LP_IDLE;
                    if (!sensor_level)
                    begin
                        lamp_timer_next = '0;
                        lamp_phase_next = srs_pkg::LP_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    assign out_valid_next = in_fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_phase_reg  <= srs_pkg::SP_IDLE;
            servo_timer_reg  <= '0;
            frame_count_reg  <= '0;
            pending_reg      <= 1'b0;
            prev_trigger_reg <= 1'b1;
            lamp_phase_reg   <= srs_pkg::LP_IDLE;
            lamp_timer_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                servo_phase_reg  <= servo_phase_next;
                servo_timer_reg  <= servo_timer_next;
                frame_count_reg  <= frame_count_next;
                pending_reg      <= pending_next;
                prev_trigger_reg <= trigger_level;
                lamp_phase_reg   <= lamp_phase_next;
                lamp_timer_reg   <= lamp_timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            servo_drive_reg  <= (servo_phase_next == srs_pkg::SP_OPEN_HIGH)
                             || (servo_phase_next == srs_pkg::SP_CLOSE_HIGH);
            lamp_drive_reg   <= lamp_phase_next == srs_pkg::LP_LIT;
            servo_active_reg <= servo_phase_next != srs_pkg::SP_IDLE;
        end
    end

    `ASSERT_NEVER(a_drive_needs_active, clk, rst_n,
        out_valid_reg && servo_drive_reg && !servo_active_reg)
    `ASSERT_PROP(a_lamp_frozen_when_busy, clk, rst_n,
        !$stable(lamp_phase_reg) |-> (servo_phase_reg == srs_pkg::SP_IDLE))
    `ASSERT_PROP(a_idle_exits_to_debounce, clk, rst_n,
        (in_fire && servo_phase_reg == srs_pkg::SP_IDLE)
        |=> (servo_phase_reg == srs_pkg::SP_IDLE || servo_phase_reg == srs_pkg::SP_DEBOUNCE))
    `ASSERT_PROP(a_state_holds_without_item, clk, rst_n,
        !in_fire |=> ($stable(servo_phase_reg) && $stable(lamp_phase_reg)
                      && $stable(servo_timer_reg)))

endmodule
